@@ rtl/bhm_pkg.sv @@
// bhm_pkg: shared types and constants of the box heat map update block
// holds request and result payload structs, register codes and defaults
// no dependencies
package bhm_pkg;

    localparam int MAX_BOXES_DEF = 16;

    localparam int COORD_W  = 12;
    localparam int SPAN_W   = 13;
    localparam int BOUND_W  = 14;
    localparam int HEAT_W   = 8;
    localparam int INDEX_W  = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [HEAT_W-1:0] HEAT_MAX = 8'd255;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEAT_INCREASE    = 2'd0,
        REG_HEAT_DECREASE    = 2'd1,
        REG_APPEAR_THRESHOLD = 2'd2
    } cfg_reg_t;

    localparam logic [HEAT_W-1:0] HEAT_INCREASE_RST    = 8'd10;
    localparam logic [HEAT_W-1:0] HEAT_DECREASE_RST    = 8'd5;
    localparam logic [HEAT_W-1:0] APPEAR_THRESHOLD_RST = 8'd128;

    typedef struct packed {
        logic               command;
        logic [INDEX_W-1:0] box_index;
        logic               box_valid;
        logic [COORD_W-1:0] box_top;
        logic [COORD_W-1:0] box_left;
        logic [SPAN_W-1:0]  box_height;
        logic [SPAN_W-1:0]  box_width;
        logic [COORD_W-1:0] pixel_row;
        logic [COORD_W-1:0] pixel_col;
        logic [HEAT_W-1:0]  old_heat;
    } item_t;

    typedef struct packed {
        logic [HEAT_W-1:0] new_heat;
        logic              clear_id;
        logic              hit;
    } result_t;

    typedef struct packed {
        logic [HEAT_W-1:0] heat_increase;
        logic [HEAT_W-1:0] heat_decrease;
        logic [HEAT_W-1:0] appear_threshold;
    } cfg_t;

    // one table write, issued from the first pipeline stage
    typedef struct packed {
        logic               en;
        logic [INDEX_W-1:0] index;
        logic               valid;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] left;
        logic [SPAN_W-1:0]  height;
        logic [SPAN_W-1:0]  width;
    } box_wr_t;

endpackage

@@ rtl/box_heat_map_update.sv @@
// box_heat_map_update: top level, box table loads and pixel heat updates
// depends on bhm_pkg, bhm_box_table, bhm_heat_update
//
//  channel   direction  handshake                    payload
//  item      in         item_valid / item_stall      item_t   (load or pixel request)
//  result    out        result_valid / result_stall  result_t (one per pixel request)
//  cfg       in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// one request enters per cycle while item_stall is low; a pixel request passes s1, s2, s3
// and then the result register, each of them registered, before result_valid rises
// stages: s1 table hit test per entry, s2 or of hits and heat arithmetic,
// s3 threshold compare, then the result register
// a load request writes its table entry from s1 and leaves the pipeline there
// reset empties the pipeline, marks every box invalid and loads register defaults
// a held result stalls only the stages behind it that are full; no request is lost
module box_heat_map_update
    import bhm_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,

    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HEAT_W-1:0]    cfg_data
);

    // configuration registers
    cfg_t cfg_reg;

    // stage 1: request as accepted
    logic  s1_valid_reg;
    item_t s1_item_reg;

    // stage 2: per-entry hits of one pixel
    logic                 s2_valid_reg;
    logic [MAX_BOXES-1:0] s2_match_reg;
    logic [HEAT_W-1:0]    s2_heat_reg;

    // stage 3: updated heat
    logic              s3_valid_reg;
    logic              s3_hit_reg;
    logic [HEAT_W-1:0] s3_heat_reg;

    // output register
    logic    result_valid_reg;
    result_t result_reg;

    // stage readiness, back from the output
    logic out_free;
    logic s3_free;
    logic s2_free;
    logic s1_free;
    logic s1_is_load;

    box_wr_t              box_wr;
    logic [MAX_BOXES-1:0] match;
    logic                 s2_hit;
    logic [HEAT_W-1:0]    s2_new_heat;

    assign cfg_ready = 1'b1;

    assign s1_is_load = (s1_item_reg.command == CMD_LOAD);
    assign out_free   = !result_valid_reg || !result_stall;
    assign s3_free    = !s3_valid_reg || out_free;
    assign s2_free    = !s2_valid_reg || s3_free;
    // a load never waits, it ends in s1
    assign s1_free    = !s1_valid_reg || s1_is_load || s2_free;
    assign item_stall = !s1_free;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // table write from s1 so it lands in request order with the pixel tests
    always_comb
    begin
        box_wr.en     = s1_valid_reg && s1_is_load;
        box_wr.index  = s1_item_reg.box_index;
        box_wr.valid  = s1_item_reg.box_valid;
        box_wr.top    = s1_item_reg.box_top;
        box_wr.left   = s1_item_reg.box_left;
        box_wr.height = s1_item_reg.box_height;
        box_wr.width  = s1_item_reg.box_width;
    end

    bhm_box_table #(
        .MAX_BOXES (MAX_BOXES)
    ) u_box_table (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (box_wr),
        .row   (s1_item_reg.pixel_row),
        .col   (s1_item_reg.pixel_col),
        .match (match)
    );

    assign s2_hit = |s2_match_reg;

    bhm_heat_update u_heat_update (
        .hit      (s2_hit),
        .old_heat (s2_heat_reg),
        .cfg      (cfg_reg),
        .new_heat (s2_new_heat)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heat_increase    <= HEAT_INCREASE_RST;
            cfg_reg.heat_decrease    <= HEAT_DECREASE_RST;
            cfg_reg.appear_threshold <= APPEAR_THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HEAT_INCREASE:    cfg_reg.heat_increase    <= cfg_data;
                REG_HEAT_DECREASE:    cfg_reg.heat_decrease    <= cfg_data;
                REG_APPEAR_THRESHOLD: cfg_reg.appear_threshold <= cfg_data;
                default:              ;
            endcase
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg && !s1_is_load;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                result_valid_reg <= s3_valid_reg;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (s1_free && item_valid)
        begin
            s1_item_reg <= item;
        end
        if (s2_free && s1_valid_reg && !s1_is_load)
        begin
            s2_match_reg <= match;
            s2_heat_reg  <= s1_item_reg.old_heat;
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_hit_reg  <= s2_hit;
            s3_heat_reg <= s2_new_heat;
        end
        if (out_free && s3_valid_reg)
        begin
            result_reg.new_heat <= s3_heat_reg;
            result_reg.clear_id <= (s3_heat_reg < cfg_reg.appear_threshold);
            result_reg.hit      <= s3_hit_reg;
        end
    end

    // an empty first stage always takes a request
    a_s1_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !item_stall)
        else $error("request stalled with empty first stage");

    // a pixel held in stage 2 by a full stage 3 is not dropped
    a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s3_free |=> s2_valid_reg)
        else $error("stalled pixel lost in stage 2");

    // a hit never yields heat below the heat increase amount
    a_hit_heat: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && s3_free
        |=> !(result_reg.hit
              && (result_reg.new_heat < $past(cfg_reg.heat_increase))))
        else $error("hit produced heat below the increase amount");

    // identity clear follows the delivered heat and threshold
    a_clear_id: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg
        |-> (result_reg.clear_id == (result_reg.new_heat < cfg_reg.appear_threshold)))
        else $error("clear_id disagrees with heat and threshold");

endmodule

@@ rtl/bhm_box_table.sv @@
// bhm_box_table: candidate box registers and one hit-test lane per entry
// depends on bhm_pkg
module bhm_box_table
    import bhm_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  box_wr_t              wr,
    input  logic [COORD_W-1:0]   row,
    input  logic [COORD_W-1:0]   col,
    output logic [MAX_BOXES-1:0] match
);

    logic [MAX_BOXES-1:0] valid_reg;
    logic [COORD_W-1:0]   top_reg    [MAX_BOXES];
    logic [COORD_W-1:0]   left_reg   [MAX_BOXES];
    logic [BOUND_W-1:0]   bottom_reg [MAX_BOXES];
    logic [BOUND_W-1:0]   right_reg  [MAX_BOXES];

    logic [BOUND_W-1:0] bottom_next;
    logic [BOUND_W-1:0] right_next;

    // exclusive bounds kept precomputed so the lanes only compare
    assign bottom_next = BOUND_W'(wr.top) + BOUND_W'(wr.height);
    assign right_next  = BOUND_W'(wr.left) + BOUND_W'(wr.width);

    for (genvar i = 0; i < MAX_BOXES; i++)
    begin : g_entry
        logic sel;

        // indexes past the table never select an entry
        assign sel = wr.en && (32'(wr.index) == 32'(i));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (sel)
            begin
                valid_reg[i] <= wr.valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (sel)
            begin
                top_reg[i]    <= wr.top;
                left_reg[i]   <= wr.left;
                bottom_reg[i] <= bottom_next;
                right_reg[i]  <= right_next;
            end
        end

        assign match[i] = valid_reg[i]
                        && (row >= top_reg[i])
                        && (BOUND_W'(row) < bottom_reg[i])
                        && (col > left_reg[i])
                        && (BOUND_W'(col) < right_reg[i]);
    end

endmodule

@@ rtl/bhm_heat_update.sv @@
// bhm_heat_update: saturating heat increase on a hit, clamped decrease on a miss
// depends on bhm_pkg
module bhm_heat_update
    import bhm_pkg::*;
(
    input  logic              hit,
    input  logic [HEAT_W-1:0] old_heat,
    input  cfg_t              cfg,
    output logic [HEAT_W-1:0] new_heat
);

    logic [HEAT_W:0] sum;

    assign sum = {1'b0, old_heat} + {1'b0, cfg.heat_increase};

    always_comb
    begin
        if (hit)
        begin
            new_heat = sum[HEAT_W] ? HEAT_MAX : sum[HEAT_W-1:0];
        end
        else if (old_heat > cfg.heat_decrease)
        begin
            new_heat = old_heat - cfg.heat_decrease;
        end
        else
        begin
            new_heat = '0;
        end
    end

endmodule

@@ tb/box_heat_map_update_test.sv @@
`timescale 1ns / 1ps
// box_heat_map_update_test: self-checking testbench for the box heat map update block
// a scoreboard class keeps its own box table and registers and predicts every pixel result
// depends on bhm_pkg and box_heat_map_update
module box_heat_map_update_test
    import bhm_pkg::*;
();

    localparam int CLK_HALF_NS   = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 225;
    // pipeline is four stages deep; the settle wait lets a load still in flight land
    localparam int SETTLE_CYCLES = 10;
    // time limit set well above the slowest legal run
    localparam int TIMEOUT_NS    = 4_000_000;

    // one entry of the predicted box table
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] left;
        logic [SPAN_W-1:0]  height;
        logic [SPAN_W-1:0]  width;
    } box_rec_t;

    // prediction of the heat update and in-order comparison of results
    class heat_scoreboard;
        box_rec_t boxes[MAX_BOXES_DEF];
        cfg_t     regs;
        result_t  expected_heat[$];
        int       errors;
        int       loads;
        int       pixels;
        int       hits;
        int       clears;

        function new();
            foreach (boxes[i])
                boxes[i] = '0;
            regs.heat_increase    = HEAT_INCREASE_RST;
            regs.heat_decrease    = HEAT_DECREASE_RST;
            regs.appear_threshold = APPEAR_THRESHOLD_RST;
            errors = 0;
            loads  = 0;
            pixels = 0;
            hits   = 0;
            clears = 0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [HEAT_W-1:0] v);
            case (r)
                REG_HEAT_INCREASE:    regs.heat_increase    = v;
                REG_HEAT_DECREASE:    regs.heat_decrease    = v;
                REG_APPEAR_THRESHOLD: regs.appear_threshold = v;
                default: ;
            endcase
        endfunction

        // bounds are summed at full width so oversize spans reach past the frame
        function bit covers(box_rec_t b, logic [COORD_W-1:0] row,
                            logic [COORD_W-1:0] col);
            logic [BOUND_W-1:0] row_w;
            logic [BOUND_W-1:0] col_w;
            logic [BOUND_W-1:0] top_w;
            logic [BOUND_W-1:0] left_w;
            logic [BOUND_W-1:0] height_w;
            logic [BOUND_W-1:0] width_w;
            row_w    = BOUND_W'(row);
            col_w    = BOUND_W'(col);
            top_w    = BOUND_W'(b.top);
            left_w   = BOUND_W'(b.left);
            height_w = BOUND_W'(b.height);
            width_w  = BOUND_W'(b.width);
            // left edge strict, right and bottom edges exclusive
            return b.valid && (row_w >= top_w) && (row_w < top_w + height_w)
                && (col_w > left_w) && (col_w < left_w + width_w);
        endfunction

        function void note_item(item_t it);
            result_t          r;
            logic             hit;
            logic [HEAT_W:0]  sum;
            if (it.command == CMD_LOAD)
            begin
                // a 4-bit index always lands inside the 16-entry table
                boxes[it.box_index].valid  = it.box_valid;
                boxes[it.box_index].top    = it.box_top;
                boxes[it.box_index].left   = it.box_left;
                boxes[it.box_index].height = it.box_height;
                boxes[it.box_index].width  = it.box_width;
                loads++;
            end
            else
            begin
                hit = 1'b0;
                foreach (boxes[i])
                    if (covers(boxes[i], it.pixel_row, it.pixel_col))
                        hit = 1'b1;
                if (hit)
                begin
                    sum        = {1'b0, it.old_heat} + {1'b0, regs.heat_increase};
                    r.new_heat = sum[HEAT_W] ? HEAT_MAX : sum[HEAT_W-1:0];
                end
                else
                begin
                    r.new_heat = (it.old_heat > regs.heat_decrease)
                               ? it.old_heat - regs.heat_decrease : '0;
                end
                r.clear_id = (r.new_heat < regs.appear_threshold);
                r.hit      = hit;
                pixels++;
                hits   += hit;
                clears += r.clear_id;
                expected_heat = {expected_heat, r};
            end
        endfunction

        task report(string msg);
            errors++;
            $display("%0t ns  mismatch: %s", $time, msg);
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_heat.size() == 0)
            begin
                report($sformatf("result with no pixel request pending (heat %0d)",
                    got.new_heat));
            end
            else
            begin
                want = expected_heat.pop_front();
                if (got.new_heat !== want.new_heat)
                    report($sformatf("new_heat %0d, predicted %0d", got.new_heat,
                        want.new_heat));
                if (got.clear_id !== want.clear_id)
                    report($sformatf("clear_id %b, predicted %b", got.clear_id,
                        want.clear_id));
                if (got.hit !== want.hit)
                    report($sformatf("hit %b, predicted %b", got.hit, want.hit));
            end
        endtask
    endclass

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    item_t                item         = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [HEAT_W-1:0]    cfg_data     = '0;

    // both sides insert idle bursts while this is set
    bit                   idle_en      = 1'b1;
    int                   settings     = 0;
    heat_scoreboard       board;

    box_heat_map_update dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // ---------------------------------------------------------------- request builders

    // load request; pixel fields carry junk since a load ignores them
    function automatic item_t load_req(logic [INDEX_W-1:0] idx, logic valid,
                                       logic [COORD_W-1:0] top, logic [COORD_W-1:0] left,
                                       logic [SPAN_W-1:0] height, logic [SPAN_W-1:0] width);
        item_t it;
        it            = item_t'({$urandom, $urandom, $urandom});
        it.command    = CMD_LOAD;
        it.box_index  = idx;
        it.box_valid  = valid;
        it.box_top    = top;
        it.box_left   = left;
        it.box_height = height;
        it.box_width  = width;
        return it;
    endfunction

    // pixel request; box fields carry junk and must leave the table alone
    function automatic item_t pixel_req(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                                        logic [HEAT_W-1:0] heat);
        item_t it;
        it           = item_t'({$urandom, $urandom, $urandom});
        it.command   = CMD_PIXEL;
        it.pixel_row = row;
        it.pixel_col = col;
        it.old_heat  = heat;
        return it;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0:       return '0;
            1:       return '1;
            2, 3:    return COORD_W'($urandom_range(0, 63));
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // mostly small boxes so hits and misses stay balanced; empty and oversize too
    function automatic logic [SPAN_W-1:0] rand_span();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return '0;
            1:       return 1;
            2:       return 4096;
            3:       return SPAN_W'($urandom_range(4097, 8191));
            8, 9:    return SPAN_W'($urandom);
            default: return SPAN_W'($urandom_range(2, 40));
        endcase
    endfunction

    function automatic logic [HEAT_W-1:0] rand_heat();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0:       return '0;
            1:       return HEAT_MAX;
            default: return HEAT_W'($urandom);
        endcase
    endfunction

    // most pixels are aimed at the edges of a loaded box so the hit test gets exercised
    function automatic item_t random_req();
        box_rec_t    b;
        int unsigned pick;
        int unsigned row;
        int unsigned col;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            return load_req(INDEX_W'($urandom), $urandom_range(0, 9) != 0,
                            rand_coord(), rand_coord(), rand_span(), rand_span());
        if (pick < 80)
        begin
            b   = board.boxes[INDEX_W'($urandom_range(0, MAX_BOXES_DEF - 1))];
            row = b.top + $urandom_range(0, b.height + 1) - 1;
            col = b.left + $urandom_range(0, b.width);
            return pixel_req(row[COORD_W-1:0], col[COORD_W-1:0], rand_heat());
        end
        return pixel_req(COORD_W'($urandom), COORD_W'($urandom), rand_heat());
    endfunction

    // ---------------------------------------------------------------- drivers

    // one request, with an optional idle burst ahead of it
    task automatic send(item_t it);
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        board.note_item(it);
    endtask

    // hold requests until every predicted result is back, then let loads settle
    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.expected_heat.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // cfg_valid stays high across back-to-back writes; the caller lowers it
    task automatic put_reg(cfg_reg_t r, logic [HEAT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(r, v);
    endtask

    // hand-picked requests against the reset register values (10, 5, 128)
    task automatic directed_part();
        send(pixel_req(0, 0, 0));                   // empty table, miss clamps at zero
        send(pixel_req(4095, 4095, 255));           // largest position, miss
        send(pixel_req(100, 100, 3));               // heat below the decrease
        send(load_req(0, 1'b1, 10, 20, 5, 6));      // rows 10..14, cols 21..25
        send(pixel_req(10, 21, 250));               // hit saturates at the top
        send(pixel_req(10, 20, 100));               // on the strict left edge
        send(pixel_req(14, 25, 118));               // last row and col, heat lands on threshold
        send(pixel_req(15, 25, 117));               // one row past the bottom
        send(pixel_req(14, 26, 117));               // on the exclusive right edge
        send(pixel_req(9, 21, 117));                // one row above the top
        send(pixel_req(12, 22, 117));               // hit just below threshold
        send(load_req(1, 1'b0, 0, 0, 4096, 4096));  // invalid box over the whole frame
        send(pixel_req(2000, 2000, 50));
        send(load_req(2, 1'b1, 500, 500, 10, 1));   // width one holds nothing
        send(pixel_req(505, 500, 50));
        send(pixel_req(505, 501, 50));
        send(load_req(3, 1'b1, 600, 600, 0, 10));   // height zero holds nothing
        send(pixel_req(600, 605, 50));
        send(load_req(15, 1'b1, 4095, 4094, 8191, 8191));  // spans past the frame
        send(pixel_req(4095, 4095, 200));
        send(load_req(4, 1'b1, 0, 0, 4096, 4096));  // whole frame but column zero
        send(pixel_req(0, 0, 60));
        send(pixel_req(0, 1, 60));
        send(load_req(4, 1'b0, 0, 0, 0, 0));        // clear the frame-sized boxes again
        send(load_req(15, 1'b0, 0, 0, 0, 0));
    endtask

    // ---------------------------------------------------------------- main sequence

    initial
    begin : stimulus
        cfg_t setting;
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_part();

        for (int p = 1; p <= PHASES; p++)
        begin
            // registers change only with the pipeline empty
            wait_drained();
            case (p)
                1:       setting = {8'd0, 8'd0, 8'd0};
                2:       setting = {8'd255, 8'd255, 8'd255};
                3:       setting = {8'd255, 8'd0, 8'd1};
                4:       setting = {8'd1, 8'd255, 8'd254};
                default: setting = cfg_t'({$urandom, $urandom, $urandom});
            endcase
            put_reg(REG_HEAT_INCREASE, setting.heat_increase);
            put_reg(REG_HEAT_DECREASE, setting.heat_decrease);
            put_reg(REG_APPEAR_THRESHOLD, setting.appear_threshold);
            cfg_valid <= 1'b0;
            settings++;

            // phase 4 runs at full rate; the last phase has no idling at all
            idle_en = (p != 4) && (p != PHASES);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    wait_drained();
                send(random_req());
            end
        end

        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.expected_heat.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.expected_heat.size() != 0)
            board.report($sformatf("%0d results never arrived", board.expected_heat.size()));

        $display("covered %0d box loads and %0d pixel updates (%0d hits, %0d id clears)",
            board.loads, board.pixels, board.hits, board.clears);
        $display("over %0d register settings including both extremes, %0d mismatches",
            settings, board.errors);
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // result side holds stall in random bursts
    initial
    begin : result_side
        forever
        begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 7) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // every accepted result goes to the scoreboard
    initial
    begin : result_monitor
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                board.check_result(result);
        end
    end

    // hard limit in case a result or a handshake never comes
    initial
    begin : watchdog
        #TIMEOUT_NS;
        $display("timeout with %0d results outstanding", board.expected_heat.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bhm_pkg.sv
rtl/bhm_box_table.sv
rtl/bhm_heat_update.sv
rtl/box_heat_map_update.sv
tb/box_heat_map_update_test.sv
